FILE: src/fdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared types and constants for the FAT directory entry parser.
// ----------------------------------------------------------------------------
package fdp_pkg;

  localparam int MaxLfnPieces  = 20;
  localparam int CharsPerPiece = 13;
  localparam int StoreDepth    = MaxLfnPieces * CharsPerPiece;
  localparam int AddrW         = $clog2(StoreDepth);
  localparam int RowW          = (MaxLfnPieces > 1) ? $clog2(MaxLfnPieces) : 1;
  localparam int QueueDepth    = 2;

  localparam logic [1:0] KindFile = 2'd0;
  localparam logic [1:0] KindEnd  = 2'd1;
  localparam logic [1:0] KindChar = 2'd2;

  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] OrderMask   = 8'h3F;
  localparam logic [7:0] QuestMark   = 8'h3F;
  localparam logic [7:0] AsciiMax    = 8'h7F;
  localparam logic [7:0] AttrDir     = 8'h10;
  localparam logic [7:0] AttrHidden  = 8'h02;
  localparam logic [7:0] AttrLfn     = 8'h0F;
  localparam logic [7:0] SpaceChar   = 8'h20;
  localparam logic [7:0] DotChar     = 8'h2E;

  typedef enum logic [1:0] {
    CmdResult,
    CmdWrite,
    CmdRead
  } cmd_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        uses_long_name;
    logic [63:0] short_name_first8;
    logic [31:0] short_name_last4;
    logic [3:0]  short_name_length;
    logic        is_directory;
    logic        is_hidden;
    logic [7:0]  attributes;
    logic [31:0] start_cluster;
    logic [31:0] byte_size;
    logic [7:0]  name_char;
  } res_t;

  typedef struct packed {
    cmd_e                                cmd;
    res_t                                res;
    logic [CharsPerPiece-1:0][7:0]       chars;
    logic [RowW-1:0]                     row;
    logic [AddrW-1:0]                    base;
    logic [AddrW-1:0]                    addr;
    logic                                hit;
  } entry_t;

endpackage
`default_nettype wire

FILE: src/fdp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_front
// Accepts items, classifies entries, formats short names and tracks the
// pending long-name order; emits one command per item that needs work.
// ----------------------------------------------------------------------------
module fdp_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic            operation_i,
  input  wire logic [63:0]     entry_bytes_0_7_i,
  input  wire logic [63:0]     entry_bytes_8_15_i,
  input  wire logic [63:0]     entry_bytes_16_23_i,
  input  wire logic [63:0]     entry_bytes_24_31_i,
  input  wire logic [8:0]      char_index_i,
  output fdp_pkg::entry_t      entry_o,
  output logic                 push_o
);

  logic [4:0]        pending_q, pending_d;
  logic [31:0][7:0]  bytes;
  logic [7:0]        b0, attr;
  logic [5:0]        order;
  logic              is_lfn, lfn_ok;
  logic [10:0][7:0]  raw;
  logic [11:0][7:0]  name;
  logic [3:0]        bl, el, dl, len;
  logic              run_b, run_e, run_d, dot;
  logic [18:0]       prod;
  logic [4:0]        wr_row;
  logic [15:0]       w;
  logic [fdp_pkg::CharsPerPiece-1:0][7:0] chars;

  localparam int CharPos [fdp_pkg::CharsPerPiece] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22,
                                                      24, 28, 30};

  assign bytes  = {entry_bytes_24_31_i, entry_bytes_16_23_i,
                   entry_bytes_8_15_i, entry_bytes_0_7_i};
  assign b0     = bytes[0];
  assign attr   = bytes[11];
  assign order  = b0[5:0] & fdp_pkg::OrderMask[5:0];
  assign is_lfn = (attr & fdp_pkg::AttrLfn) == fdp_pkg::AttrLfn;
  assign lfn_ok = (order != 6'd0) && (order <= 6'(fdp_pkg::MaxLfnPieces));
  assign wr_row = 5'(order - 6'd1);
  assign prod   = 19'(char_index_i) * 19'd631;

  always_comb begin
    w = '0;
    for (int j = 0; j < fdp_pkg::CharsPerPiece; j++) begin
      w = {bytes[CharPos[j]+1], bytes[CharPos[j]]};
      chars[j] = (w <= 16'(fdp_pkg::AsciiMax)) ? w[7:0] : fdp_pkg::QuestMark;
    end
  end

  // short name: base up to first NUL, dot, extension up to first NUL (a leading dot keeps up to three bytes only)
  always_comb begin
    for (int j = 0; j < 11; j++)
      raw[j] = (bytes[j] == fdp_pkg::SpaceChar) ? 8'd0 : bytes[j];
    dot = raw[0] == fdp_pkg::DotChar;
    bl = '0; run_b = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (run_b && raw[k] != 8'd0) bl = bl + 4'd1;
      else run_b = 1'b0;
    end
    el = '0; run_e = 1'b1;
    for (int k = 8; k < 11; k++) begin
      if (run_e && raw[k] != 8'd0) el = el + 4'd1;
      else run_e = 1'b0;
    end
    dl = '0; run_d = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (run_d && raw[k] != 8'd0) dl = dl + 4'd1;
      else run_d = 1'b0;
    end
    name = '0;
    if (dot) begin
      for (int k = 0; k < 3; k++)
        if (4'(k) < dl) name[k] = raw[k];
      len = dl;
    end else begin
      for (int k = 0; k < 8; k++)
        if (4'(k) < bl) name[k] = raw[k];
      name[bl] = fdp_pkg::DotChar;
      for (int e = 0; e < 3; e++)
        if (4'(e) < el) name[bl + 4'(e + 1)] = raw[8 + e];
      len = bl + 4'd1 + el;
    end
  end

  always_comb begin
    entry_o       = '0;
    push_o        = 1'b0;
    pending_d     = pending_q;
    entry_o.chars = chars;
    if (operation_i) begin
      entry_o.cmd          = fdp_pkg::CmdRead;
      entry_o.hit          = char_index_i < 9'(fdp_pkg::StoreDepth);
      entry_o.row          = prod[17:13];
      entry_o.addr         = entry_o.hit ? char_index_i : '0;
      push_o               = 1'b1;
    end else begin
      pending_d = '0;
      if (b0 == 8'd0) begin
        entry_o.cmd      = fdp_pkg::CmdResult;
        entry_o.res.kind = fdp_pkg::KindEnd;
        push_o           = 1'b1;
      end else if (b0 == fdp_pkg::DeletedMark) begin
        push_o = 1'b0;
      end else if (is_lfn) begin
        if (lfn_ok) begin
          entry_o.cmd  = fdp_pkg::CmdWrite;
          entry_o.row  = wr_row;
          entry_o.base = 9'(wr_row) * 9'(fdp_pkg::CharsPerPiece);
          pending_d    = 5'(order);
          push_o       = 1'b1;
        end
      end else begin
        entry_o.cmd          = fdp_pkg::CmdResult;
        entry_o.res.kind     = fdp_pkg::KindFile;
        if (pending_q == 5'd1) begin
          entry_o.res.uses_long_name = 1'b1;
        end else begin
          entry_o.res.short_name_first8 = name[7:0];
          entry_o.res.short_name_last4  = name[11:8];
          entry_o.res.short_name_length = len;
        end
        entry_o.res.is_directory  = (attr & fdp_pkg::AttrDir) != 8'd0;
        entry_o.res.is_hidden     = (attr & fdp_pkg::AttrHidden) != 8'd0;
        entry_o.res.attributes    = attr;
        entry_o.res.start_cluster = {bytes[21], bytes[20], bytes[27], bytes[26]};
        entry_o.res.byte_size     = {bytes[31], bytes[30], bytes[29], bytes[28]};
        push_o                    = 1'b1;
      end
    end
    push_o = push_o && accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (accept_i && !operation_i) begin
      pending_q <= pending_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/fdp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module fdp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  fdp_pkg::entry_t      entry_i,
  input  wire logic            pop_i,
  output fdp_pkg::entry_t      head_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int PtrW = (fdp_pkg::QueueDepth > 1) ? $clog2(fdp_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(fdp_pkg::QueueDepth + 1);

  fdp_pkg::entry_t mem_q [fdp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == CntW'(fdp_pkg::QueueDepth);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push)
        wr_q <= (wr_q == PtrW'(fdp_pkg::QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)
        rd_q <= (rd_q == PtrW'(fdp_pkg::QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule
`default_nettype wire

FILE: src/fdp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_back
// Carries out queued commands: writes long-name pieces into the byte-wide
// name store, reads characters back and presents results.
// ----------------------------------------------------------------------------
module fdp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  fdp_pkg::entry_t      head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output fdp_pkg::res_t        res_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i
);

  typedef enum logic [1:0] {
    StIdle,
    StWrite,
    StRead
  } state_e;

  state_e                                  state_q;
  logic [3:0]                              cnt_q;
  logic [fdp_pkg::CharsPerPiece-1:0][7:0]  chars_q;
  logic [fdp_pkg::AddrW-1:0]               base_q;
  logic [fdp_pkg::MaxLfnPieces-1:0]        row_valid_q;
  logic                                    hit_q;
  fdp_pkg::res_t                           res_q, rd_res;
  logic                                    out_valid_q;
  logic [7:0]                              mem_q [fdp_pkg::StoreDepth];
  logic [7:0]                              rd_data_q;
  logic                                    out_free, mem_we, mem_re;
  logic [fdp_pkg::AddrW-1:0]               mem_wa;

  assign out_free = !out_valid_q || !out_stall_i;
  assign mem_we   = state_q == StWrite;
  assign mem_wa   = base_q + fdp_pkg::AddrW'(cnt_q);

  always_comb begin
    pop_o  = 1'b0;
    mem_re = 1'b0;
    if (state_q == StIdle && !empty_i) begin
      case (head_i.cmd)
        fdp_pkg::CmdWrite: pop_o = 1'b1;
        fdp_pkg::CmdRead: begin
          pop_o  = out_free;
          mem_re = out_free;
        end
        default: pop_o = out_free;
      endcase
    end
  end

  always_comb begin
    rd_res           = '0;
    rd_res.kind      = fdp_pkg::KindChar;
    rd_res.name_char = hit_q ? rd_data_q : 8'd0;
  end

  // name store: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= chars_q[cnt_q];
    if (mem_re) rd_data_q <= mem_q[head_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      chars_q     <= '0;
      base_q      <= '0;
      row_valid_q <= '0;
      hit_q       <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (pop_o) begin
            case (head_i.cmd)
              fdp_pkg::CmdWrite: begin
                chars_q                  <= head_i.chars;
                base_q                   <= head_i.base;
                cnt_q                    <= '0;
                row_valid_q[head_i.row]  <= 1'b1;
                state_q                  <= StWrite;
              end
              fdp_pkg::CmdRead: begin
                hit_q   <= head_i.hit && row_valid_q[head_i.row];
                state_q <= StRead;
              end
              default: begin
                res_q       <= head_i.res;
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        StWrite: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(fdp_pkg::CharsPerPiece - 1)) state_q <= StIdle;
        end
        StRead: begin
          res_q       <= rd_res;
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_o       = res_q;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: src/fat_directory_entry_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fat_directory_entry_parser
// FAT directory entry parser with long-name pieces and a name store.
// ----------------------------------------------------------------------------
// Path: file and end entries pass the command queue and the result register;
// character reads also pass the registered name-store read. Throughput: file
// and end entries one a cycle while results flow; a read holds the back end
// in its read state before the next command; a long-name piece holds it for
// the pop, then 13 writes, one a cycle on the byte-wide store port.
// Reset: clears the pending order, queue, output and 20 row valid bits at
// once; no clearing pass, unwritten rows read as zero.
// ----------------------------------------------------------------------------
module fat_directory_entry_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [63:0] entry_bytes_0_7_i,
  input  wire logic [63:0] entry_bytes_8_15_i,
  input  wire logic [63:0] entry_bytes_16_23_i,
  input  wire logic [63:0] entry_bytes_24_31_i,
  input  wire logic [8:0]  char_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic             uses_long_name_o,
  output logic [63:0]      short_name_first8_o,
  output logic [31:0]      short_name_last4_o,
  output logic [3:0]       short_name_length_o,
  output logic             is_directory_o,
  output logic             is_hidden_o,
  output logic [7:0]       attributes_o,
  output logic [31:0]      start_cluster_o,
  output logic [31:0]      byte_size_o,
  output logic [7:0]       name_char_o
);

  fdp_pkg::entry_t entry, head;
  fdp_pkg::res_t   res;
  logic            push, pop, empty, full, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  fdp_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .operation_i         (operation_i),
    .entry_bytes_0_7_i   (entry_bytes_0_7_i),
    .entry_bytes_8_15_i  (entry_bytes_8_15_i),
    .entry_bytes_16_23_i (entry_bytes_16_23_i),
    .entry_bytes_24_31_i (entry_bytes_24_31_i),
    .char_index_i        (char_index_i),
    .entry_o             (entry),
    .push_o              (push)
  );

  fdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  fdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_o       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  assign kind_o              = res.kind;
  assign uses_long_name_o    = res.uses_long_name;
  assign short_name_first8_o = res.short_name_first8;
  assign short_name_last4_o  = res.short_name_last4;
  assign short_name_length_o = res.short_name_length;
  assign is_directory_o      = res.is_directory;
  assign is_hidden_o         = res.is_hidden;
  assign attributes_o        = res.attributes;
  assign start_cluster_o     = res.start_cluster;
  assign byte_size_o         = res.byte_size;
  assign name_char_o         = res.name_char;

endmodule
`default_nettype wire
